### src/ttdf_pkg.sv
//------------------------------------------------------------------------------
// ttdf_pkg: shared types and constants of the trigger timestamp filter
// Word layouts of both channels, the queued job word and the verdict codes.
//------------------------------------------------------------------------------
`default_nettype none

package ttdf_pkg;

  // Field widths fixed by the word formats.
  localparam int unsigned BOX_W    = 6;
  localparam int unsigned STAMP_W  = 27;
  localparam int unsigned SOURCE_W = 4;
  localparam int unsigned START_W  = 28;
  localparam int unsigned MARGIN_W = 16;
  localparam int unsigned CFG_W    = 28;
  localparam int unsigned CFG_IDX_W = 1;

  // Defaults for the top-level parameters.
  localparam int unsigned BOX_COUNT_DEF     = 32;
  localparam int unsigned HISTORY_DEPTH_DEF = 10;

  // Depth of the job queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 1'b1;

  // Configuration reset values.
  localparam logic signed [START_W-1:0] START_RESET  = -28'sd1;
  localparam logic [MARGIN_W-1:0]       MARGIN_RESET = 16'd10000;

  // Verdict codes.
  localparam logic [1:0] VERDICT_NEW    = 2'd0;
  localparam logic [1:0] VERDICT_FUTURE = 2'd1;
  localparam logic [1:0] VERDICT_DUP    = 2'd2;
  localparam logic [1:0] VERDICT_EARLY  = 2'd3;

  // Input word.
  typedef struct packed {
    logic [BOX_W-1:0]    box_id;
    logic [STAMP_W-1:0]  stamp_ms;
    logic [SOURCE_W-1:0] source_code;
    logic [STAMP_W-1:0]  now_ms;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic                forwarded;
    logic [1:0]          verdict;
    logic [BOX_W-1:0]    out_box;
    logic [STAMP_W-1:0]  out_stamp_ms;
    logic [SOURCE_W-1:0] out_source;
  } out_word_t;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    in_word_t word;
    logic     future;
    logic     box_ok;
  } job_t;

endpackage

`default_nettype wire

### src/ttdf_front.sv
//------------------------------------------------------------------------------
// ttdf_front: input classification and job queue
// Flags each accepted word as from the future or with an unknown box and
// holds it in a short queue until the back part takes it.
//------------------------------------------------------------------------------
`default_nettype none

module ttdf_front #(
  parameter int unsigned BOX_COUNT = ttdf_pkg::BOX_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ttdf_pkg::in_word_t               in_word,
  input  logic [ttdf_pkg::MARGIN_W-1:0]    future_margin_ms,
  output logic                             job_valid,
  output ttdf_pkg::job_t                   job,
  input  logic                             job_pop
);
  import ttdf_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            queue_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push;
  logic [STAMP_W:0] limit;
  job_t            new_job;

  // Classify: margin check without midnight wrap, and box range check.
  always_comb begin
    limit          = {1'b0, in_word.now_ms} + (STAMP_W + 1)'(future_margin_ms);
    new_job.word   = in_word;
    new_job.future = ({1'b0, in_word.stamp_ms} > limit);
    new_job.box_ok = (in_word.box_id != '0) &&
                     (9'(in_word.box_id) <= 9'(BOX_COUNT));
  end

  assign in_ready  = (count_r != CntW'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (count_r != '0);
  assign job       = queue_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (job_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !job_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && job_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

`default_nettype wire

### src/ttdf_back.sv
//------------------------------------------------------------------------------
// ttdf_back: history lookup, update and result register
// Reads the box's history row, checks for a duplicate, writes the shifted row
// back if not future, duplicate or unknown box, and loads the result register.
//------------------------------------------------------------------------------
`default_nettype none

module ttdf_back #(
  parameter int unsigned BOX_COUNT     = ttdf_pkg::BOX_COUNT_DEF,
  parameter int unsigned HISTORY_DEPTH = ttdf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  job_valid,
  input  ttdf_pkg::job_t                        job,
  output logic                                  job_pop,
  input  logic signed [ttdf_pkg::START_W-1:0]   start_time_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ttdf_pkg::out_word_t                   out_word
);
  import ttdf_pkg::*;

  localparam int unsigned RowW  = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
  localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);

  typedef logic [HISTORY_DEPTH-1:0][STAMP_W-1:0] row_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  job_t             job_r, job_nxt;
  row_t             hist_mem [BOX_COUNT];
  row_t             row_data_r;
  row_t             new_row;
  logic [FillW-1:0] fill_r [BOX_COUNT];
  logic [FillW-1:0] cur_fill;
  logic [8:0]       head_row_wide, cur_row_wide;
  logic [RowW-1:0]  head_row, cur_row;
  logic             dup;
  logic             commit;
  logic             hist_we;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  // Row addresses of the queue head and of the word being evaluated.
  assign head_row_wide = 9'(job.word.box_id) - 9'd1;
  assign cur_row_wide  = 9'(job_r.word.box_id) - 9'd1;
  assign head_row      = head_row_wide[RowW-1:0];
  assign cur_row       = cur_row_wide[RowW-1:0];

  assign job_pop = (state_r == ST_IDLE) && job_valid;
  assign commit  = (state_r == ST_EVAL) && (!out_valid_r || out_ready);
  assign cur_fill = fill_r[cur_row];

  // Compare against the valid entries and build the shifted row.
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if ((FillW'(i) < cur_fill) && (row_data_r[i] == job_r.word.stamp_ms)) begin
        dup = 1'b1;
      end
    end
    new_row[0] = job_r.word.stamp_ms;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      new_row[i] = row_data_r[i-1];
    end
  end

  assign hist_we = commit && !job_r.future && job_r.box_ok && !dup;

  // Sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_nxt   = job;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (commit) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.out_box      = job_r.word.box_id;
          out_word_nxt.out_stamp_ms = job_r.word.stamp_ms;
          out_word_nxt.out_source   = job_r.word.source_code;
          out_word_nxt.forwarded    = 1'b0;
          if (job_r.future) begin
            out_word_nxt.verdict = VERDICT_FUTURE;
          end else if (!job_r.box_ok || dup) begin
            out_word_nxt.verdict = VERDICT_DUP;
          end else if ($signed({1'b0, job_r.word.stamp_ms}) > start_time_ms) begin
            out_word_nxt.verdict   = VERDICT_NEW;
            out_word_nxt.forwarded = 1'b1;
          end else begin
            out_word_nxt.verdict = VERDICT_EARLY;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_word_r <= out_word_nxt;
  end

  // Per-box fill counts, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BOX_COUNT; b++) begin
        fill_r[b] <= '0;
      end
    end else if (hist_we && (cur_fill != FillW'(HISTORY_DEPTH))) begin
      fill_r[cur_row] <= cur_fill + 1'b1;
    end
  end

  // History memory: one row per box, registered read.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      row_data_r <= hist_mem[head_row];
    end
    if (hist_we) begin
      hist_mem[cur_row] <= new_row;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### src/trigger_timestamp_dedup_filter.sv
//------------------------------------------------------------------------------
// trigger_timestamp_dedup_filter: duplicate filter for remote box timestamps
// Rejects timestamps too far ahead of now, from unknown boxes or seen in the
// box's recent history; flags new ones as forwarded or before the start time.
//
//   Channel  Direction  Handshake              Word
//   in_      input      in_valid / in_ready    ttdf_pkg::in_word_t
//   out_     output     out_valid / out_ready  ttdf_pkg::out_word_t
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// The back part takes each word through ST_IDLE, for the registered history
// row read, then ST_EVAL, for the compare and the row write-back once the
// result register is free; only then does it take the next word.
// Reset clears the fill counts; history rows need no clearing pass.
// A two-word queue lets input words be taken while a result waits on out_ready.
//------------------------------------------------------------------------------
`default_nettype none

module trigger_timestamp_dedup_filter #(
  parameter int unsigned BOX_COUNT     = ttdf_pkg::BOX_COUNT_DEF,
  parameter int unsigned HISTORY_DEPTH = ttdf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ttdf_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ttdf_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [ttdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttdf_pkg::CFG_W-1:0]        cfg_wdata
);
  import ttdf_pkg::*;

  logic signed [START_W-1:0] start_r, start_nxt;
  logic [MARGIN_W-1:0]       margin_r, margin_nxt;
  logic                      job_valid;
  logic                      job_pop;
  job_t                      job;

  // Configuration registers.
  always_comb begin
    start_nxt  = start_r;
    margin_nxt = margin_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START_TIME: start_nxt  = $signed(cfg_wdata[START_W-1:0]);
        REG_MARGIN:     margin_nxt = cfg_wdata[MARGIN_W-1:0];
        default: begin
          start_nxt  = start_r;
          margin_nxt = margin_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= START_RESET;
      margin_r <= MARGIN_RESET;
    end else begin
      start_r  <= start_nxt;
      margin_r <= margin_nxt;
    end
  end

  // Front part: classify and queue.
  ttdf_front #(
    .BOX_COUNT (BOX_COUNT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_word          (in_word),
    .future_margin_ms (margin_r),
    .job_valid        (job_valid),
    .job              (job),
    .job_pop          (job_pop)
  );

  // Back part: history check, update and result.
  ttdf_back #(
    .BOX_COUNT     (BOX_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop),
    .start_time_ms (start_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word)
  );

endmodule

`default_nettype wire

### tb/trigger_timestamp_dedup_filter_tb.sv
//------------------------------------------------------------------------------
// trigger_timestamp_dedup_filter_tb: self-checking bench of the timestamp filter
// Words go in through a queued driver and are predicted on acceptance by a
// model of per-box histories. The monitor compares every result word field by
// field. Both sides idle in random bursts except in the final phase, and the start time and future margin
// change between phases while the block is idle.
//------------------------------------------------------------------------------
`default_nettype none

module trigger_timestamp_dedup_filter_tb;
  import ttdf_pkg::*;

  localparam int NBOX         = BOX_COUNT_DEF;
  localparam int DEPTH        = HISTORY_DEPTH_DEF;
  localparam int DAY_MS       = 86400000;
  localparam int STAMP_MAX    = 134217727;
  localparam int LOG_LEN      = 16;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT  = 5000;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // Block ports.
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_TIME;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  trigger_timestamp_dedup_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Current register values, as the block should hold them.
  logic signed [START_W-1:0] start_cfg  = START_RESET;
  logic [MARGIN_W-1:0]       margin_cfg = MARGIN_RESET;

  // Predicted per-box history, newest entry first.
  bit [STAMP_W-1:0] hist_stamp [NBOX][DEPTH];
  int               hist_fill  [NBOX];

  // Stamps handed out per box, so that repeats can be generated.
  bit [STAMP_W-1:0] sent_log [NBOX][LOG_LEN];
  int               sent_cnt [NBOX];

  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  int idle_odds = 0;
  int send_gap  = 0;
  int recv_gap  = 0;
  int err_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int settings_run = 1;
  int stall_cycles = 0;
  int verdict_seen [4];

  // Work out the result word for one accepted word and update the history.
  function automatic out_word_t dedup_predict(in_word_t w);
    out_word_t r;
    logic [STAMP_W:0] reach;
    int row;
    bit hit;
    r.forwarded    = 1'b0;
    r.out_box      = w.box_id;
    r.out_stamp_ms = w.stamp_ms;
    r.out_source   = w.source_code;
    reach = {1'b0, w.now_ms} + (STAMP_W + 1)'(margin_cfg);
    if ({1'b0, w.stamp_ms} > reach) begin
      r.verdict = VERDICT_FUTURE;
    end else if (w.box_id == '0 || w.box_id > NBOX) begin
      r.verdict = VERDICT_DUP;
    end else begin
      row = int'(w.box_id) - 1;
      hit = 1'b0;
      for (int i = 0; i < hist_fill[row]; i++) begin
        if (hist_stamp[row][i] == w.stamp_ms) hit = 1'b1;
      end
      if (hit) begin
        r.verdict = VERDICT_DUP;
      end else begin
        for (int i = DEPTH - 1; i > 0; i--) hist_stamp[row][i] = hist_stamp[row][i - 1];
        hist_stamp[row][0] = w.stamp_ms;
        if (hist_fill[row] < DEPTH) hist_fill[row]++;
        if ($signed({1'b0, w.stamp_ms}) > start_cfg) begin
          r.forwarded = 1'b1;
          r.verdict   = VERDICT_NEW;
        end else begin
          r.verdict = VERDICT_EARLY;
        end
      end
    end
    return r;
  endfunction

  // A time base, often close to the start time so that both sides of it occur.
  function automatic int pick_now();
    int t;
    case ($urandom_range(0, 9))
      0: t = $urandom_range(0, STAMP_MAX);
      1, 2, 3, 4: begin
        if (start_cfg >= 0) t = int'(start_cfg) + int'($urandom_range(0, 40000)) - 20000;
        else t = $urandom_range(0, DAY_MS - 1);
      end
      default: t = $urandom_range(0, DAY_MS - 1);
    endcase
    if (t < 0) t = 0;
    return t;
  endfunction

  // Random word: mostly fresh stamps and repeats on a few busy boxes, plus
  // stamps from the future, unknown boxes and plain noise.
  function automatic in_word_t random_word();
    in_word_t w;
    int kind, box, now, stamp, depth, back;
    kind  = $urandom_range(0, 99);
    box   = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 4) : $urandom_range(1, NBOX);
    now   = pick_now();
    w.source_code = SOURCE_W'($urandom);
    if (kind < 45 || (kind < 75 && sent_cnt[box - 1] == 0)) begin
      if ($urandom_range(0, 9) < 3) stamp = now + int'($urandom_range(0, margin_cfg));
      else stamp = now - int'($urandom_range(0, 30000));
      if (stamp < 0) stamp = 0;
      sent_log[box - 1][sent_cnt[box - 1] % LOG_LEN] = STAMP_W'(stamp);
      sent_cnt[box - 1]++;
    end else if (kind < 75) begin
      // Repeats reach a little past the history depth to catch evicted stamps.
      depth = (sent_cnt[box - 1] < DEPTH + 4) ? sent_cnt[box - 1] : DEPTH + 4;
      back  = $urandom_range(1, depth);
      stamp = sent_log[box - 1][(sent_cnt[box - 1] - back) % LOG_LEN];
      now   = stamp + int'($urandom_range(0, 20000));
    end else if (kind < 85) begin
      stamp = now + int'(margin_cfg) + 1 + int'($urandom_range(0, 100000));
    end else if (kind < 92) begin
      box   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(NBOX + 1, 63);
      stamp = now - int'($urandom_range(0, 30000));
      if (stamp < 0) stamp = 0;
    end else begin
      box   = $urandom_range(0, 63);
      stamp = $urandom_range(0, STAMP_MAX);
      now   = $urandom_range(0, STAMP_MAX);
    end
    w.box_id   = BOX_W'(box);
    w.stamp_ms = STAMP_W'(stamp);
    w.now_ms   = STAMP_W'(now);
    return w;
  endfunction

  function automatic void queue_word(int box, int stamp, int src, int now);
    in_word_t w;
    w.box_id      = BOX_W'(box);
    w.stamp_ms    = STAMP_W'(stamp);
    w.source_code = SOURCE_W'(src);
    w.now_ms      = STAMP_W'(now);
    pending_words.push_back(w);
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [STAMP_W-1:0] got, logic [STAMP_W-1:0] want);
    if (got !== want) report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  // Register write through the plain write port; the block must be idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_TIME) start_cfg = $signed(val[START_W-1:0]);
    else margin_cfg = val[MARGIN_W-1:0];
  endtask

  // Wait until every word is taken and every result is back, then let the
  // pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(int start, int margin, int odds);
    write_reg(REG_START_TIME, CFG_W'(start));
    write_reg(REG_MARGIN, CFG_W'(margin));
    @(negedge clk);
    idle_odds = odds;
    settings_run++;
  endtask

  // Driver: predicts each accepted word, then offers the next queued word or
  // idles for a burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(dedup_predict(in_word));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_valid <= 1'b1;
          in_word  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction and
  // stalls the result channel in bursts.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result word: box %0d stamp %0d",
                                 out_word.out_box, out_word.out_stamp_ms));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          verdict_seen[want.verdict]++;
          check_field("forwarded", out_word.forwarded, want.forwarded);
          check_field("verdict", out_word.verdict, want.verdict);
          check_field("out_box", out_word.out_box, want.out_box);
          check_field("out_stamp_ms", out_word.out_stamp_ms, want.out_stamp_ms);
          check_field("out_source", out_word.out_source, want.out_source);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        recv_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: the run is stuck if no word moves on either channel for long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset settings: box range edges, the margin
    // edge, out-of-range stamps and one box pushed past its history depth.
    idle_odds = 4;
    queue_word(1, 0, 0, 0);
    queue_word(NBOX, DAY_MS - 1, 15, DAY_MS - 1);
    queue_word(0, 1000, 3, 5000);
    queue_word(NBOX + 1, 1000, 5, 5000);
    queue_word(63, 2000, 9, 5000);
    queue_word(2, 20000, 1, 10000);
    queue_word(2, 20001, 2, 10000);
    queue_word(3, STAMP_MAX, 10, STAMP_MAX);
    queue_word(3, STAMP_MAX, 11, 0);
    queue_word(1, 0, 6, 5);
    for (int k = 0; k < DEPTH; k++) queue_word(7, 1000 * (k + 1), k, 50000);
    queue_word(7, 1000, 12, 50000);
    queue_word(7, 1000 * (DEPTH + 1), 13, 50000);
    queue_word(7, 1000, 14, 50000);
    wait_drained();

    // Latest start time with no margin at all.
    set_config(DAY_MS - 1, 0, 3);
    queue_word(4, DAY_MS - 1, 7, DAY_MS - 1);
    queue_word(4, DAY_MS, 8, DAY_MS);
    repeat (250) pending_words.push_back(random_word());
    wait_drained();

    // Start at midnight with the widest margin.
    set_config(0, 60000, 6);
    queue_word(5, 0, 0, 0);
    queue_word(5, 1, 15, 1);
    repeat (250) pending_words.push_back(random_word());
    wait_drained();

    // Back to no start time and the default margin, heavy idling.
    set_config(-1, 10000, 2);
    repeat (280) pending_words.push_back(random_word());
    wait_drained();

    set_config($urandom_range(0, DAY_MS - 1), $urandom_range(0, 60000), 5);
    repeat (270) pending_words.push_back(random_word());
    wait_drained();

    // Final stretch at full rate on both sides.
    set_config($urandom_range(0, DAY_MS - 1), $urandom_range(0, 60000), 0);
    repeat (280) pending_words.push_back(random_word());
    wait_drained();

    if (expected_results.size() != 0)
      report_error($sformatf("%0d result words never arrived", expected_results.size()));

    $display("Checked %0d result words for %0d words sent under %0d register settings.",
             results_checked, words_sent, settings_run);
    $display("Verdicts: %0d new, %0d from future, %0d duplicate, %0d before start; %0d errors.",
             verdict_seen[VERDICT_NEW], verdict_seen[VERDICT_FUTURE],
             verdict_seen[VERDICT_DUP], verdict_seen[VERDICT_EARLY], err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
